>>> design/goose_retransmit_scheduler_top_defines.svh
// Assertion macros for the retransmit scheduler.
`ifndef GOOSE_RETRANSMIT_SCHEDULER_TOP_DEFINES_SVH
`define GOOSE_RETRANSMIT_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication
`define GRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/grs_pkg.sv
// Shared types and constants for the retransmit scheduler.
package grs_pkg;

	localparam int INTERVAL_BITS_DEF = 16;
	localparam int REG_W             = 16;
	localparam int TTL_W             = 17;
	localparam int CNT_W             = 32;
	localparam int TIME_W            = 64;
	localparam int CFG_IDX_W         = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_RETX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT  = 2'd1;

	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam logic [REG_W-1:0] FIRST_RETX_RST = 16'd4;
	localparam logic [REG_W-1:0] HEARTBEAT_RST  = 16'd1000;

	typedef struct packed {
		logic [REG_W-1:0] first_retx;
		logic [REG_W-1:0] heartbeat;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0]  state_number;
		logic [CNT_W-1:0]  sequence_number;
		logic [TTL_W-1:0]  time_to_live_ms;
		logic [TIME_W-1:0] change_time_ns;
		logic              frame_value;
	} result_t;

endpackage

>>> design/grs_cfg.sv
// Configuration register file: first retransmit interval and heartbeat.
module grs_cfg
	import grs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_retx <= FIRST_RETX_RST;
			cfg_q.heartbeat  <= HEARTBEAT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FIRST_RETX: cfg_q.first_retx <= cfg_data;
				CFG_HEARTBEAT:  cfg_q.heartbeat  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> design/grs_core.sv
// Input register, scheduler state and single-pass wake/emit logic.
module grs_core
	import grs_pkg::*;
#(
	parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic              sample_value,
	input  logic [TIME_W-1:0] sample_time_ns,
	input  logic [TIME_W-1:0] now_ns,
	input  cfg_t              cfg,
	input  logic              full,
	output logic              push,
	output result_t           push_data
);

	localparam int IB = INTERVAL_BITS;
	localparam logic [32:0] IVL_MAX = (33'd1 << IB) - 33'd1;

	function automatic logic [IB-1:0] clamp_ivl(input logic [REG_W-1:0] v);
		logic [IB-1:0] r;
		if (33'(v) > IVL_MAX)
			r = IB'(IVL_MAX);
		else
			r = IB'(v);
		return r;
	endfunction

	// input stage
	logic              valid_s1;
	logic              cmd_s1;
	logic              value_s1;
	logic [TIME_W-1:0] stime_s1;
	logic [TIME_W-1:0] now_s1;

	// scheduler state
	logic              have_q;
	logic              cached_q;
	logic [CNT_W-1:0]  state_cnt_q;
	logic [CNT_W-1:0]  seq_cnt_q;
	logic [TIME_W-1:0] change_time_q;
	logic [IB-1:0]     ivl_q;
	logic [IB-1:0]     countdown_q;
	logic              pend_valid_q;
	logic              pend_value_q;
	logic [TIME_W-1:0] pend_time_q;

	logic          wake;
	logic          change;
	logic          emit;
	logic          advance;
	logic [IB-1:0] hb;
	logic [IB-1:0] first;
	logic [IB:0]   dbl;
	logic [IB-1:0] ramp;
	logic [IB-1:0] ivl_retx;
	logic [IB-1:0] ivl_emit;

	assign hb    = clamp_ivl(cfg.heartbeat);
	assign first = clamp_ivl(cfg.first_retx);

	assign wake   = valid_s1 && (cmd_s1 == CMD_TICK) && (countdown_q <= IB'(1));
	assign change = pend_valid_q && (!have_q || (pend_value_q != cached_q));
	assign emit   = wake && (change || have_q);

	assign advance  = valid_s1 && (!emit || !full);
	assign in_ready = !valid_s1 || advance;
	assign push     = advance && emit;

	// doubling ramp, capped at heartbeat; kept when already at or above it
	assign dbl      = {ivl_q, 1'b0};
	assign ramp     = (dbl > {1'b0, hb}) ? hb : dbl[IB-1:0];
	assign ivl_retx = (ivl_q < hb) ? ramp : ivl_q;
	assign ivl_emit = change ? first : ivl_q;

	always_comb begin
		push_data.state_number    = change ? (have_q ? state_cnt_q + CNT_W'(1) : CNT_W'(1))
		                                   : state_cnt_q;
		push_data.sequence_number = change ? '0 : seq_cnt_q + CNT_W'(1);
		push_data.time_to_live_ms = TTL_W'({ivl_emit, 1'b0});
		push_data.change_time_ns  = change ? ((pend_time_q != '0) ? pend_time_q : now_s1)
		                                   : change_time_q;
		push_data.frame_value     = change ? pend_value_q : cached_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1   <= cmd;
			value_s1 <= sample_value;
			stime_s1 <= sample_time_ns;
			now_s1   <= now_ns;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q        <= 1'b0;
			cached_q      <= 1'b0;
			state_cnt_q   <= '0;
			seq_cnt_q     <= '0;
			change_time_q <= '0;
			ivl_q         <= IB'(FIRST_RETX_RST);
			countdown_q   <= '0;
			pend_valid_q  <= 1'b0;
			pend_value_q  <= 1'b0;
			pend_time_q   <= '0;
		end else if (advance) begin
			if (cmd_s1 == CMD_SAMPLE) begin
				pend_valid_q <= 1'b1;
				pend_value_q <= value_s1;
				pend_time_q  <= stime_s1;
			end else if (!wake) begin
				countdown_q <= countdown_q - IB'(1);
			end else begin
				pend_valid_q <= 1'b0;
				if (change) begin
					have_q        <= 1'b1;
					cached_q      <= pend_value_q;
					state_cnt_q   <= push_data.state_number;
					seq_cnt_q     <= '0;
					change_time_q <= push_data.change_time_ns;
					ivl_q         <= first;
					countdown_q   <= first;
				end else if (have_q) begin
					seq_cnt_q   <= push_data.sequence_number;
					ivl_q       <= ivl_retx;
					countdown_q <= ivl_retx;
				end else begin
					countdown_q <= hb;
				end
			end
		end
	end

endmodule

>>> design/grs_fifo.sv
// Two-entry result queue between the scheduler and the output channel.
module grs_fifo
	import grs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	result_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/goose_retransmit_scheduler_top.sv
// Top level of the retransmission scheduler for boolean status frames.
//
//  channel  direction  handshake              beat
//  in       sink       in_valid / in_ready    cmd, sample_value, sample_time_ns, now_ns
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//  out      source     out_valid / out_ready  frame descriptor fields
//
// One beat per cycle while in_ready is high; a beat is registered in the input stage,
// then handled by the scheduler logic, and its frame sits in a two-entry queue.
// The rate is set by the state update, no loop is involved.
// Reset clears the scheduler state and loads the register defaults; cfg_ready is always high.
// When the queue is full and a wake would emit, the input register holds and in_ready drops.
`include "goose_retransmit_scheduler_top_defines.svh"

module goose_retransmit_scheduler_top
	import grs_pkg::*;
#(
	parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic                 sample_value,
	input  logic [TIME_W-1:0]    sample_time_ns,
	input  logic [TIME_W-1:0]    now_ns,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CNT_W-1:0]     state_number,
	output logic [CNT_W-1:0]     sequence_number,
	output logic [TTL_W-1:0]     time_to_live_ms,
	output logic [TIME_W-1:0]    change_time_ns,
	output logic                 frame_value
);

	cfg_t    cfg;
	logic    full;
	logic    push;
	result_t push_data;
	result_t out_data;

	grs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	grs_core #(
		.INTERVAL_BITS (INTERVAL_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.sample_value   (sample_value),
		.sample_time_ns (sample_time_ns),
		.now_ns         (now_ns),
		.cfg            (cfg),
		.full           (full),
		.push           (push),
		.push_data      (push_data)
	);

	grs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign state_number    = out_data.state_number;
	assign sequence_number = out_data.sequence_number;
	assign time_to_live_ms = out_data.time_to_live_ms;
	assign change_time_ns  = out_data.change_time_ns;
	assign frame_value     = out_data.frame_value;

	`GRS_ASSERT_IMPLY(a_no_overflow, clk, arst_n, push, !full, "frame pushed into full queue")
	`GRS_ASSERT_IMPLY(a_ttl_even, clk, arst_n, out_valid, !time_to_live_ms[0], "odd time to live")
	`GRS_ASSERT_NEXT(a_push_shows, clk, arst_n, push, out_valid, "pushed frame not visible")

endmodule

>>> tb/goose_retransmit_scheduler_top_test.sv
// Testbench for the retransmit scheduler: directed table, then random predictor-checked phases.
module goose_retransmit_scheduler_top_test;
	import grs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_EVERY = 200;
	localparam logic [TIME_W-1:0] T_MAX = '1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_HEARTBEAT + 1'b1;
	localparam result_t NO_FRAME = '0;

	typedef struct packed {
		logic              c;
		logic              v;
		logic [TIME_W-1:0] st;
		logic [TIME_W-1:0] nw;
	} in_beat_t;

	typedef struct packed {
		in_beat_t beat;
		logic     pinned;
		result_t  frame;
	} row_t;

	typedef struct packed {
		logic [REG_W-1:0] first;
		logic [REG_W-1:0] hb;
		int               send_pct;
		int               recv_pct;
		int               items;
		int               min_frames;
		int               sample_pct;
	} phase_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 cmd = CMD_TICK;
	logic                 sample_value = 1'b0;
	logic [TIME_W-1:0]    sample_time_ns = '0;
	logic [TIME_W-1:0]    now_ns = '0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_FIRST_RETX;
	logic [REG_W-1:0]     cfg_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [CNT_W-1:0]     state_number;
	logic [CNT_W-1:0]     sequence_number;
	logic [TTL_W-1:0]     time_to_live_ms;
	logic [TIME_W-1:0]    change_time_ns;
	logic                 frame_value;

	// predictor state
	logic              p_have = 1'b0;
	logic              p_value = 1'b0;
	logic [CNT_W-1:0]  p_state = '0;
	logic [CNT_W-1:0]  p_seq = '0;
	logic [TIME_W-1:0] p_change = '0;
	logic [REG_W-1:0]  p_ivl = FIRST_RETX_RST;
	logic [REG_W-1:0]  p_count = '0;
	logic              p_pend = 1'b0;
	logic              p_pend_val = 1'b0;
	logic [TIME_W-1:0] p_pend_t = '0;
	logic [REG_W-1:0]  p_first = FIRST_RETX_RST;
	logic [REG_W-1:0]  p_hb = HEARTBEAT_RST;

	result_t frames_due[$];
	int      frames_booked = 0;
	int      mismatches = 0;
	int      send_pct = 0;
	int      recv_pct = 0;
	int      idle_cycles = 0;

	// settings (first_retx, heartbeat) = (1, 4) while this runs
	row_t plan [0:23] = '{
		'{'{CMD_TICK,   1'b0, 64'd0, 64'd0}, 1'b0, NO_FRAME},
		'{'{CMD_SAMPLE, 1'b1, 64'd0, 64'd0}, 1'b0, NO_FRAME},
		'{'{CMD_TICK,   1'b0, 64'd0, 64'd0}, 1'b0, NO_FRAME},
		'{'{CMD_TICK,   1'b0, 64'd0, 64'd0}, 1'b0, NO_FRAME},
		'{'{CMD_TICK,   1'b0, 64'd0, 64'd0}, 1'b0, NO_FRAME},
		'{'{CMD_TICK,   1'b0, 64'd0, T_MAX}, 1'b1, '{32'd1, 32'd0, 17'd2, T_MAX, 1'b1}},
		'{'{CMD_TICK,   1'b0, 64'd0, 64'd0}, 1'b1, '{32'd1, 32'd1, 17'd2, T_MAX, 1'b1}},
		'{'{CMD_TICK,   1'b0, 64'd0, 64'd0}, 1'b0, NO_FRAME},
		'{'{CMD_TICK,   1'b0, 64'd0, 64'd0}, 1'b0, NO_FRAME},
		'{'{CMD_SAMPLE, 1'b0, T_MAX, 64'd0}, 1'b0, NO_FRAME},
		'{'{CMD_SAMPLE, 1'b1, 64'd1, 64'd0}, 1'b0, NO_FRAME},
		'{'{CMD_TICK,   1'b0, 64'd0, 64'd0}, 1'b0, NO_FRAME},
		'{'{CMD_TICK,   1'b0, 64'd0, 64'd0}, 1'b0, NO_FRAME},
		'{'{CMD_TICK,   1'b0, 64'd0, 64'd0}, 1'b0, NO_FRAME},
		'{'{CMD_TICK,   1'b0, 64'd0, 64'd0}, 1'b0, NO_FRAME},
		'{'{CMD_SAMPLE, 1'b0, T_MAX, 64'd0}, 1'b0, NO_FRAME},
		'{'{CMD_TICK,   1'b0, 64'd0, 64'd0}, 1'b0, NO_FRAME},
		'{'{CMD_TICK,   1'b0, 64'd0, 64'd0}, 1'b0, NO_FRAME},
		'{'{CMD_TICK,   1'b0, 64'd0, 64'd0}, 1'b0, NO_FRAME},
		'{'{CMD_TICK,   1'b0, 64'd0, 64'd0}, 1'b1, '{32'd2, 32'd0, 17'd2, T_MAX, 1'b0}},
		'{'{CMD_SAMPLE, 1'b1, 64'd0, T_MAX}, 1'b0, NO_FRAME},
		'{'{CMD_TICK,   1'b0, T_MAX, 64'h8000_0000_0000_0001}, 1'b1,
			'{32'd3, 32'd0, 17'd2, 64'h8000_0000_0000_0001, 1'b1}},
		'{'{CMD_SAMPLE, 1'b1, 64'h5A5A_C3C3_0F0F_9696, 64'd0}, 1'b0, NO_FRAME},
		'{'{CMD_TICK,   1'b0, 64'd0, 64'd0}, 1'b0, NO_FRAME}
	};

	phase_t phases [0:6] = '{
		'{16'd1, 16'd4, 0, 0, 400, 0, 25},
		'{16'd0, 16'd3, 75, 0, 300, 0, 25},
		'{16'd2, 16'd0, 0, 75, 300, 0, 25},
		'{FIRST_RETX_RST, HEARTBEAT_RST, 28, 28, 300, 0, 25},
		'{16'd1, 16'hFFFF, 0, 0, 150, 0, 10},
		'{16'd7, 16'd5, 28, 28, 150, 0, 25},
		'{16'hFFFF, 16'hFFFF, 0, 0, 20, 1, 1}
	};

	goose_retransmit_scheduler_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.sample_value   (sample_value),
		.sample_time_ns (sample_time_ns),
		.now_ns         (now_ns),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.state_number   (state_number),
		.sequence_number(sequence_number),
		.time_to_live_ms(time_to_live_ms),
		.change_time_ns (change_time_ns),
		.frame_value    (frame_value)
	);

	always #4 clk = ~clk;

	function automatic logic advance_schedule(input in_beat_t b, output result_t f);
		logic [REG_W:0] dbl;
		f = '0;
		if (b.c == CMD_SAMPLE) begin
			p_pend = 1'b1;
			p_pend_val = b.v;
			p_pend_t = b.st;
			return 1'b0;
		end
		if (p_count > 1) begin
			p_count = p_count - 1'b1;
			return 1'b0;
		end
		if (p_pend) begin
			p_pend = 1'b0;
			if (!p_have || p_pend_val != p_value) begin
				p_state = p_have ? p_state + 1'b1 : CNT_W'(1);
				p_have = 1'b1;
				p_value = p_pend_val;
				p_seq = '0;
				p_change = (p_pend_t != '0) ? p_pend_t : b.nw;
				p_ivl = p_first;
				p_count = p_ivl;
				f = '{p_state, p_seq, {p_ivl, 1'b0}, p_change, p_value};
				return 1'b1;
			end
		end
		if (!p_have) begin
			p_count = p_hb;
			return 1'b0;
		end
		p_seq = p_seq + 1'b1;
		f = '{p_state, p_seq, {p_ivl, 1'b0}, p_change, p_value};
		// interval above a lowered heartbeat is kept
		if (p_ivl < p_hb) begin
			dbl = {p_ivl, 1'b0};
			p_ivl = (dbl > p_hb) ? p_hb : dbl[REG_W-1:0];
		end
		p_count = p_ivl;
		return 1'b1;
	endfunction

	task automatic send_beat(input in_beat_t b, input logic pinned, input result_t pinned_frame);
		result_t f;
		logic    fired;
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= b.c;
		sample_value <= b.v;
		sample_time_ns <= b.st;
		now_ns <= b.nw;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		fired = advance_schedule(b, f);
		if (pinned) begin
			frames_due.push_back(pinned_frame);
		end else if (fired) begin
			frames_due.push_back(f);
		end
		if (pinned || fired)
			frames_booked++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		case (idx)
			CFG_FIRST_RETX: p_first = val;
			CFG_HEARTBEAT: p_hb = val;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [REG_W-1:0] first, input logic [REG_W-1:0] hb);
		write_reg(CFG_FIRST_RETX, first);
		write_reg(CFG_UNUSED_LO + CFG_IDX_W'($urandom_range(1)), REG_W'($urandom));
		write_reg(CFG_HEARTBEAT, hb);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_pct);

	always @(negedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frames_due.size() == 0) begin
				$error("frame with none expected: state_number %0d sequence_number %0d",
					state_number, sequence_number);
				mismatches++;
			end else begin
				want = frames_due.pop_front();
				if (state_number !== want.state_number) begin
					$error("state_number: expected %0d, got %0d", want.state_number, state_number);
					mismatches++;
				end
				if (sequence_number !== want.sequence_number) begin
					$error("sequence_number: expected %0d, got %0d",
						want.sequence_number, sequence_number);
					mismatches++;
				end
				if (time_to_live_ms !== want.time_to_live_ms) begin
					$error("time_to_live_ms: expected %0d, got %0d",
						want.time_to_live_ms, time_to_live_ms);
					mismatches++;
				end
				if (change_time_ns !== want.change_time_ns) begin
					$error("change_time_ns: expected %0h, got %0h",
						want.change_time_ns, change_time_ns);
					mismatches++;
				end
				if (frame_value !== want.frame_value) begin
					$error("frame_value: expected %0d, got %0d", want.frame_value, frame_value);
					mismatches++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		in_beat_t b;
		int       n;
		int       booked_at;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apply_settings(16'd1, 16'd4);
		foreach (plan[i])
			send_beat(plan[i].beat, plan[i].pinned, plan[i].frame);
		in_valid <= 1'b0;

		foreach (phases[k]) begin
			drain();
			apply_settings(phases[k].first, phases[k].hb);
			send_pct = phases[k].send_pct;
			recv_pct = phases[k].recv_pct;
			booked_at = frames_booked;
			// open each phase with a change of value
			b.c = CMD_SAMPLE;
			b.v = ~p_value;
			b.st = {$urandom, $urandom};
			b.nw = {$urandom, $urandom};
			send_beat(b, 1'b0, NO_FRAME);
			for (n = 0; n < phases[k].items || frames_booked - booked_at < phases[k].min_frames;
					n++) begin
				b.c = ($urandom_range(99) < phases[k].sample_pct) ? CMD_SAMPLE : CMD_TICK;
				b.v = 1'($urandom_range(1));
				case ($urandom_range(7))
					0, 1: b.st = '0;
					2: b.st = T_MAX;
					default: b.st = {$urandom, $urandom};
				endcase
				b.nw = ($urandom_range(15) == 0) ? T_MAX : {$urandom, $urandom};
				send_beat(b, 1'b0, NO_FRAME);
				if (n % DRAIN_EVERY == DRAIN_EVERY - 1) begin
					in_valid <= 1'b0;
					drain();
				end
			end
			in_valid <= 1'b0;
		end

		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
